[design/framed_message_ring_buffer_unit_defines.svh]
// Assertion macros for the framed message ring buffer.
// No dependencies; included by the top level.
`ifndef FRAMED_MESSAGE_RING_BUFFER_UNIT_DEFINES_SVH
`define FRAMED_MESSAGE_RING_BUFFER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define FMRB_ASSERT_IMPL(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("fmrb assertion failed");
`define FMRB_ASSERT_NEXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("fmrb assertion failed");
`else
`define FMRB_ASSERT_IMPL(lbl, ck, rn, a, c)
`define FMRB_ASSERT_NEXT(lbl, ck, rn, a, c)
`endif
`endif

[design/fmrb_pkg.sv]
// Shared types and constants for the framed message ring buffer.
// No dependencies.
package fmrb_pkg;

  localparam int STORE_BYTES_DEF = 4096;
  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int HEADER_BYTES    = 8;
  localparam logic [7:0]  SIGN_BYTE = 8'ha5;
  localparam logic [31:0] FRAME_SIGN = 32'ha5a5a5a5;
  localparam logic [7:0]  MARK_BYTE = 8'h41;
  localparam logic [12:0] CAP_RESET = 13'd4096;
  localparam logic [12:0] CAP_MIN = 13'd16;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FETCH = 2'd2,
    ACT_PEEK  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_CORRUPT  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_BUSY     = 3'd5,
    ST_NOFRAME  = 3'd6
  } status_t;

  localparam logic [2:0] CFG_IDX_CAPACITY = 3'd0;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] length;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic [6:0] frame_length;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       load_item;
    logic       p_load_wr;
    logic       p_load_rd;
    logic       hdr_wr;
    logic [2:0] hdr_idx;
    logic       commit_begin;
    logic       pay_wr;
    logic       hdr_rd;
    logic       pay_rd;
    logic       clear_ring;
    logic       commit_fetch;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_data;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       open_nz;
    logic       begin_ok;
    logic       empty;
    logic       sign_ok;
    logic       flen_ok;
    logic [6:0] flen;
    logic       out_free;
  } stat_t;

endpackage

[design/fmrb_ctrl.sv]
// Sequencer for the framed message ring buffer.
// Depends on fmrb_pkg.
module fmrb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fmrb_pkg::stat_t stat,
  output fmrb_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_BEG_WR, S_BEG_DONE, S_HDR_RD, S_HDR_WAIT, S_CHECK,
    S_RESP, S_ZERO, S_PAY_RD, S_PAY_WAIT, S_PAY_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [2:0] st_r, st_nxt;
  logic       is_fetch, pay_last;

  assign in_stall = (state_r != S_IDLE);
  assign is_fetch = (stat.action == fmrb_pkg::ACT_FETCH);
  assign pay_last = ((cnt_r + 7'd1) == stat.flen);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.hdr_idx = cnt_r[2:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cnt_nxt = '0;
        case (stat.action)
          fmrb_pkg::ACT_BEGIN: begin
            if (stat.open_nz) begin
              st_nxt = fmrb_pkg::ST_BUSY;
              state_nxt = S_RESP;
            end else if (!stat.begin_ok) begin
              st_nxt = fmrb_pkg::ST_NOSPACE;
              state_nxt = S_RESP;
            end else begin
              cmd.p_load_wr = 1'b1;
              state_nxt = S_BEG_WR;
            end
          end
          fmrb_pkg::ACT_WRITE: begin
            if (!stat.open_nz) begin
              st_nxt = fmrb_pkg::ST_NOFRAME;
            end else begin
              cmd.pay_wr = 1'b1;
              st_nxt = fmrb_pkg::ST_OK;
            end
            state_nxt = S_RESP;
          end
          default: begin
            if (stat.open_nz) begin
              st_nxt = fmrb_pkg::ST_BUSY;
              state_nxt = S_RESP;
            end else if (stat.empty) begin
              st_nxt = fmrb_pkg::ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              cmd.p_load_rd = 1'b1;
              state_nxt = S_HDR_RD;
            end
          end
        endcase
      end
      S_BEG_WR: begin
        cmd.hdr_wr = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd7) state_nxt = S_BEG_DONE;
      end
      S_BEG_DONE: begin
        cmd.commit_begin = 1'b1;
        st_nxt = fmrb_pkg::ST_OK;
        state_nxt = S_RESP;
      end
      S_HDR_RD: begin
        cmd.hdr_rd = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd7) state_nxt = S_HDR_WAIT;
      end
      S_HDR_WAIT: state_nxt = S_CHECK;
      S_CHECK: begin
        cnt_nxt = '0;
        if (!stat.sign_ok) begin
          cmd.clear_ring = 1'b1;
          st_nxt = fmrb_pkg::ST_CORRUPT;
          state_nxt = S_RESP;
        end else if (!stat.flen_ok) begin
          st_nxt = fmrb_pkg::ST_OVERFLOW;
          state_nxt = S_RESP;
        end else if (stat.flen == 7'd0) begin
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_PAY_RD;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_status = st_r;
          cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ZERO: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_status = fmrb_pkg::ST_OK;
          cmd.emit_last = 1'b1;
          cmd.commit_fetch = is_fetch;
          state_nxt = S_IDLE;
        end
      end
      S_PAY_RD: begin
        cmd.pay_rd = 1'b1;
        state_nxt = S_PAY_WAIT;
      end
      S_PAY_WAIT: state_nxt = S_PAY_OUT;
      S_PAY_OUT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_status = fmrb_pkg::ST_OK;
          cmd.emit_data = 1'b1;
          cmd.emit_last = pay_last;
          cnt_nxt = cnt_r + 7'd1;
          if (pay_last) begin
            cmd.commit_fetch = is_fetch;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_PAY_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      st_r    <= fmrb_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

[design/fmrb_dp.sv]
// Datapath: byte ring memory, pointers, header capture, result register.
// Depends on fmrb_pkg.
module fmrb_dp #(
  parameter int STORE_BYTES = fmrb_pkg::STORE_BYTES_DEF,
  parameter int MAX_PAYLOAD = fmrb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fmrb_pkg::in_item_t in_data,
  input  logic               cfg_we,
  input  logic [12:0]        cfg_wdata,
  output logic [12:0]        cap_q,
  input  fmrb_pkg::cmd_t     cmd,
  output fmrb_pkg::stat_t    stat,
  output logic               out_valid,
  input  logic               out_stall,
  output fmrb_pkg::out_item_t out_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = AW + 1;
  localparam int EW = (CW > 13) ? CW : 13;
  localparam int FW = (CW > 8) ? CW : 8;
  localparam logic [EW-1:0] STORE_W = EW'(STORE_BYTES);
  localparam logic [FW-1:0] HDR_W = FW'(fmrb_pkg::HEADER_BYTES);
  localparam logic [31:0] MAXP_W = 32'(MAX_PAYLOAD);

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data_r;
  logic [12:0]   cap_r;
  logic [AW-1:0] rd_ptr_r, wr_ptr_r, p_r;
  logic [CW-1:0] free_r, effcap;
  logic [6:0]    open_r;
  fmrb_pkg::in_item_t item_r;
  logic [63:0]   hdr_r;
  logic          hdr_cap_r;
  logic          out_valid_r;
  fmrb_pkg::out_item_t out_r;

  logic [AW-1:0] p_adv, wr_adv;
  logic          wen;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata, hbyte;
  logic [FW-1:0] need, free_w;
  logic [FW:0]   fsum;
  logic          out_free;

  function automatic logic [CW-1:0] clamp_cap(input logic [12:0] c);
    logic [EW-1:0] w;
    w = EW'(c);
    if (c < fmrb_pkg::CAP_MIN) w = EW'(fmrb_pkg::CAP_MIN);
    else if (w > STORE_W) w = STORE_W;
    return w[CW-1:0];
  endfunction

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = {1'b0, p} + CW'(1);
    if (s == c) s = '0;
    return s[AW-1:0];
  endfunction

  assign effcap = clamp_cap(cap_r);
  assign cap_q  = cap_r;
  assign p_adv  = adv(p_r, effcap);
  assign wr_adv = adv(wr_ptr_r, effcap);
  assign need   = FW'(item_r.length) + HDR_W;
  assign free_w = FW'(free_r);
  assign fsum   = {1'b0, free_w} + (FW+1)'(hdr_r[38:32]) + (FW+1)'(HDR_W);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (cmd.hdr_idx)
      3'd4:    hbyte = {1'b0, item_r.length};
      3'd5, 3'd6, 3'd7: hbyte = 8'd0;
      default: hbyte = fmrb_pkg::SIGN_BYTE;
    endcase
  end

  always_comb begin
    wen = cmd.hdr_wr || cmd.pay_wr || cmd.commit_fetch;
    if (cmd.hdr_wr) begin
      waddr = p_r;
      wdata = hbyte;
    end else if (cmd.pay_wr) begin
      waddr = wr_ptr_r;
      wdata = item_r.write_byte;
    end else begin
      waddr = rd_ptr_r;
      wdata = fmrb_pkg::MARK_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (cmd.hdr_rd || cmd.pay_rd) rd_data_r <= mem[p_r];
  end

  always_comb begin
    stat.action   = item_r.action;
    stat.open_nz  = (open_r != 7'd0);
    stat.begin_ok = (item_r.length <= 7'(MAX_PAYLOAD)) && (need <= free_w);
    stat.empty    = (free_r >= effcap);
    stat.sign_ok  = (hdr_r[31:0] == fmrb_pkg::FRAME_SIGN);
    stat.flen_ok  = (hdr_r[63:32] <= {25'd0, item_r.length}) && (hdr_r[63:32] <= MAXP_W);
    stat.flen     = hdr_r[38:32];
    stat.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (hdr_cap_r) hdr_r <= {rd_data_r, hdr_r[63:8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= fmrb_pkg::CAP_RESET;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      p_r         <= '0;
      free_r      <= clamp_cap(fmrb_pkg::CAP_RESET);
      open_r      <= '0;
      hdr_cap_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      hdr_cap_r <= cmd.hdr_rd;
      if (cfg_we) begin
        cap_r    <= cfg_wdata;
        rd_ptr_r <= '0;
        wr_ptr_r <= '0;
        free_r   <= clamp_cap(cfg_wdata);
        open_r   <= '0;
      end else if (cmd.clear_ring) begin
        rd_ptr_r <= '0;
        wr_ptr_r <= '0;
        free_r   <= effcap;
        open_r   <= '0;
      end else begin
        if (cmd.p_load_wr) p_r <= wr_ptr_r;
        else if (cmd.p_load_rd) p_r <= rd_ptr_r;
        else if (cmd.hdr_wr || cmd.hdr_rd || cmd.pay_rd) p_r <= p_adv;
        if (cmd.commit_begin) begin
          wr_ptr_r <= p_r;
          free_r   <= CW'(free_w - need);
          open_r   <= item_r.length;
        end
        if (cmd.pay_wr) begin
          wr_ptr_r <= wr_adv;
          open_r   <= open_r - 7'd1;
        end
        if (cmd.commit_fetch) begin
          rd_ptr_r <= p_r;
          free_r   <= (fsum > (FW+1)'(effcap)) ? effcap : CW'(fsum);
        end
      end
      if (cmd.emit) begin
        out_valid_r        <= 1'b1;
        out_r.status       <= cmd.emit_status;
        out_r.read_byte    <= cmd.emit_data ? rd_data_r : 8'd0;
        out_r.frame_length <= cmd.emit_data ? hdr_r[38:32] : 7'd0;
        out_r.last         <= cmd.emit_last;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/framed_message_ring_buffer_unit.sv]
// Framed message ring buffer: length-prefixed frames in a byte ring.
// Begin writes the eight header bytes, then commits the frame.
// Fetch/peek read the header and check it, then read each payload byte in turn
// through the registered read port of the ring memory; an empty payload gives one result.
// One request in flight at a time. Reset (synchronous, rst_n low) empties the ring
// and sets capacity to 4096; memory is not cleared.
module framed_message_ring_buffer_unit #(
  parameter int STORE_BYTES = fmrb_pkg::STORE_BYTES_DEF,
  parameter int MAX_PAYLOAD = fmrb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmrb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fmrb_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

`include "framed_message_ring_buffer_unit_defines.svh"

  fmrb_pkg::cmd_t  cmd;
  fmrb_pkg::stat_t stat;
  logic            cfg_we;
  logic [12:0]     cap_q;
  logic            cap_sel;

  assign cap_sel    = (cfg_paddr[2] == fmrb_pkg::CFG_IDX_CAPACITY[0]);
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cap_sel;
  assign cfg_prdata = cap_sel ? {19'd0, cap_q} : 32'd0;

  fmrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fmrb_dp #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_pwdata[12:0]),
    .cap_q     (cap_q),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `FMRB_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)
  `FMRB_ASSERT_IMPL(a_err_single, clk, rst_n,
    out_valid && out_data.status != fmrb_pkg::ST_OK, out_data.last)
  `FMRB_ASSERT_IMPL(a_mid_has_len, clk, rst_n,
    out_valid && !out_data.last, out_data.frame_length != 7'd0)
  `FMRB_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, stat.out_free)

endmodule
